FILE: rtl/integer_to_ascii_formatter_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the integer to ASCII formatter
// Clocked on clock, disabled while reset is high.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// consequent must hold in the same cycle as the antecedent
`define ITAF_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ITAF_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

FILE: rtl/itaf_pkg.sv
// ----------------------------------------------------------------------------
// itaf_pkg
// Types, character codes and the digit symbol lookup for the formatter.
// ----------------------------------------------------------------------------
package itaf_pkg;

   localparam int MAX_DIGITS = 64;
   localparam int DIV_STEPS  = 64;

   localparam logic [5:0] RADIX_MIN = 6'd2;
   localparam logic [5:0] RADIX_MAX = 6'd36;
   localparam logic [5:0] RADIX_OCT = 6'd8;
   localparam logic [5:0] RADIX_HEX = 6'd16;

   localparam logic [5:0] NUM_SYMBOLS = 6'd36;
   localparam logic [5:0] X_SYMBOL    = 6'd33;

   localparam logic [7:0] CHAR_NUL   = 8'h00;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_PLUS  = 8'h2B;
   localparam logic [7:0] CHAR_MINUS = 8'h2D;
   localparam logic [7:0] CHAR_ZERO  = 8'h30;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;

   typedef enum logic [1:0] {
      STATUS_OK       = 2'd0,
      STATUS_BAD_BASE = 2'd1,
      STATUS_TRUNC    = 2'd2
   } status_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic store;
      logic setup;
      logic size;
      logic bound;
      logic emit;
      logic err;
   } cmd_type;

   typedef struct packed {
      logic bad_base;
      logic div_done;
      logic more_digits;
      logic emit_last;
   } sts_type;

   // symbol for one digit value, 0-9 then A-Z or a-z
   function automatic logic [7:0] digit_char(input logic [5:0] d, input logic lower);
      logic [5:0] v;
      v = (d >= NUM_SYMBOLS) ? d - NUM_SYMBOLS : d;
      if (v < 6'd10) begin
         digit_char = CHAR_ZERO + 8'(v);
      end else begin
         digit_char = (lower ? CHAR_LOWER_A : CHAR_UPPER_A) + 8'(v - 6'd10);
      end
   endfunction

endpackage

FILE: rtl/itaf_ctrl.sv
// ----------------------------------------------------------------------------
// itaf_ctrl
// Sequencer: accepts a request, runs the digit divisions, sets up the
// layout and steps through the output characters.
// ----------------------------------------------------------------------------
module itaf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   output logic              rsp_valid,
   output itaf_pkg::cmd_type cmd,
   input  itaf_pkg::sts_type sts
);

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_DIV   = 8'b0000_0010,
      ST_STORE = 8'b0000_0100,
      ST_SETUP = 8'b0000_1000,
      ST_SIZE  = 8'b0001_0000,
      ST_BOUND = 8'b0010_0000,
      ST_EMIT  = 8'b0100_0000,
      ST_ERR   = 8'b1000_0000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd.load = 1'b1;
               state_in = sts.bad_base ? ST_ERR : ST_DIV;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (sts.div_done) begin
               state_in = ST_STORE;
            end
         end
         ST_STORE: begin
            cmd.store = 1'b1;
            state_in  = sts.more_digits ? ST_DIV : ST_SETUP;
         end
         ST_SETUP: begin
            cmd.setup = 1'b1;
            state_in  = ST_SIZE;
         end
         ST_SIZE: begin
            cmd.size = 1'b1;
            state_in = ST_BOUND;
         end
         ST_BOUND: begin
            cmd.bound = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            cmd.emit = 1'b1;
            if (sts.emit_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_ERR: begin
            cmd.err  = 1'b1;
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = (state_ff == ST_EMIT) || (state_ff == ST_ERR);

endmodule

FILE: rtl/itaf_dpath.sv
// ----------------------------------------------------------------------------
// itaf_dpath
// Datapath: bit-serial restoring divider, digit memory, layout arithmetic
// and the character select for each output position.
// ----------------------------------------------------------------------------
module itaf_dpath #(
   parameter int MAX_CHARS = 64
) (
   input  logic              clock,
   input  itaf_pkg::cmd_type cmd,
   output itaf_pkg::sts_type sts,
   input  logic [63:0]       req_value,
   input  logic [5:0]        req_radix,
   input  logic [5:0]        req_min_width,
   input  logic [5:0]        req_min_digits,
   input  logic              req_left_justify,
   input  logic              req_force_plus,
   input  logic              req_space_sign,
   input  logic              req_alternate_prefix,
   input  logic              req_zero_pad,
   input  logic              req_lower_case,
   input  logic              req_signed_value,
   output logic [7:0]        rsp_character,
   output logic              rsp_last,
   output logic [1:0]        rsp_status
);

   localparam logic [7:0] MaxChars = 8'(MAX_CHARS);

   logic [5:0] digit_mem [itaf_pkg::MAX_DIGITS];

   // latched request
   logic [5:0] radix_ff, width_ff, min_digits_ff;
   logic       left_ff, alt_ff, zpad_ff, lower_ff;
   logic       has_sign_ff, has_sign_in;
   logic [7:0] sign_char_ff, sign_char_in;
   logic       mag_nz_ff;

   // divider
   logic [63:0] quot_ff, quot_in;
   logic [5:0]  rem_ff, rem_in;
   logic [5:0]  bit_cnt_ff, bit_cnt_in;
   logic [6:0]  n_ff, n_in;

   // layout
   logic [6:0] prec_ff, prec_in;
   logic       pfx_ff, pfx_in;
   logic       zf_ff, zf_in;
   logic [6:0] size_ff, size_in;
   logic [6:0] emit_n_ff, emit_n_in;
   logic       ovf_ff, ovf_in;
   logic [7:0] b_lead_ff, b_sign_ff, b_pfx_ff, b_zf_ff, b_pz_ff, b_dig_ff;
   logic [7:0] b_lead_in, b_sign_in, b_pfx_in, b_zf_in, b_pz_in, b_dig_in;

   // emission
   logic [6:0] pos_ff, pos_in;
   logic [5:0] ptr_ff, ptr_in;
   logic [5:0] rd_ff;

   logic        neg;
   logic [63:0] mag;
   logic [6:0]  trial;
   logic [6:0]  diff;
   logic        fits;
   logic [6:0]  min7;
   logic [6:0]  prec_raw;
   logic        oct_bump;
   logic [7:0]  used;
   logic [7:0]  width8;
   logic [7:0]  total;
   logic [7:0]  pos8;
   logic        in_digits;
   logic [7:0]  char_sel;

   assign neg   = req_signed_value && req_value[63];
   assign mag   = neg ? (64'd0 - req_value) : req_value;
   assign trial = {rem_ff, quot_ff[63]};
   assign diff  = trial - {1'b0, radix_ff};
   assign fits  = (trial >= {1'b0, radix_ff});
   assign min7  = {1'b0, min_digits_ff};
   assign prec_raw = (min7 > n_ff) ? min7 : n_ff;
   // octal alternate form: add a leading zero unless one is already there
   assign oct_bump = alt_ff && (radix_ff == itaf_pkg::RADIX_OCT) && (min7 <= n_ff) && mag_nz_ff;
   assign used   = 8'(has_sign_ff) + (pfx_ff ? 8'd2 : 8'd0) + {1'b0, prec_ff};
   assign width8 = {2'b00, width_ff};
   assign total  = (width8 > used) ? width8 : used;
   assign pos8   = {1'b0, pos_ff};
   assign in_digits = (pos8 >= b_pz_ff) && (pos8 < b_dig_ff);

   always_comb begin
      has_sign_in  = has_sign_ff;
      sign_char_in = sign_char_ff;
      quot_in      = quot_ff;
      rem_in       = rem_ff;
      bit_cnt_in   = bit_cnt_ff;
      n_in         = n_ff;
      prec_in      = prec_ff;
      pfx_in       = pfx_ff;
      zf_in        = zf_ff;
      size_in      = size_ff;
      emit_n_in    = emit_n_ff;
      ovf_in       = ovf_ff;
      b_lead_in    = b_lead_ff;
      b_sign_in    = b_sign_ff;
      b_pfx_in     = b_pfx_ff;
      b_zf_in      = b_zf_ff;
      b_pz_in      = b_pz_ff;
      b_dig_in     = b_dig_ff;
      pos_in       = pos_ff;
      ptr_in       = ptr_ff;

      if (cmd.load) begin
         has_sign_in  = neg || req_force_plus || req_space_sign;
         sign_char_in = neg ? itaf_pkg::CHAR_MINUS :
                        (req_force_plus ? itaf_pkg::CHAR_PLUS : itaf_pkg::CHAR_SPACE);
         quot_in      = mag;
         rem_in       = '0;
         bit_cnt_in   = '0;
         n_in         = '0;
      end
      if (cmd.div_step) begin
         rem_in     = fits ? diff[5:0] : trial[5:0];
         quot_in    = {quot_ff[62:0], fits};
         bit_cnt_in = bit_cnt_ff + 6'd1;
      end
      if (cmd.store) begin
         n_in       = n_ff + 7'd1;
         rem_in     = '0;
         bit_cnt_in = '0;
      end
      if (cmd.setup) begin
         prec_in = oct_bump ? (n_ff + 7'd1) : prec_raw;
         pfx_in  = alt_ff && (radix_ff == itaf_pkg::RADIX_HEX) && mag_nz_ff;
         zf_in   = zpad_ff && !left_ff && (min_digits_ff == 6'd0);
         ptr_in  = n_ff[5:0] - 6'd1;
      end
      if (cmd.size) begin
         size_in   = (width8 > used) ? 7'(width8 - used) : 7'd0;
         ovf_in    = (total > MaxChars);
         emit_n_in = (total > MaxChars) ? MaxChars[6:0] : total[6:0];
      end
      if (cmd.bound) begin
         b_lead_in = (!zf_ff && !left_ff) ? {1'b0, size_ff} : 8'd0;
         b_sign_in = b_lead_in + 8'(has_sign_ff);
         b_pfx_in  = b_sign_in + (pfx_ff ? 8'd2 : 8'd0);
         b_zf_in   = b_pfx_in + (zf_ff ? {1'b0, size_ff} : 8'd0);
         b_pz_in   = b_zf_in + {1'b0, prec_ff - n_ff};
         b_dig_in  = b_pz_in + {1'b0, n_ff};
         pos_in    = '0;
      end
      if (cmd.emit) begin
         pos_in = pos_ff + 7'd1;
         if (in_digits) begin
            ptr_in = ptr_ff - 6'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         radix_ff      <= req_radix;
         width_ff      <= req_min_width;
         min_digits_ff <= req_min_digits;
         left_ff       <= req_left_justify;
         alt_ff        <= req_alternate_prefix;
         zpad_ff       <= req_zero_pad;
         lower_ff      <= req_lower_case;
         mag_nz_ff     <= (mag != 64'd0);
      end
      has_sign_ff  <= has_sign_in;
      sign_char_ff <= sign_char_in;
      quot_ff      <= quot_in;
      rem_ff       <= rem_in;
      bit_cnt_ff   <= bit_cnt_in;
      n_ff         <= n_in;
      prec_ff      <= prec_in;
      pfx_ff       <= pfx_in;
      zf_ff        <= zf_in;
      size_ff      <= size_in;
      emit_n_ff    <= emit_n_in;
      ovf_ff       <= ovf_in;
      b_lead_ff    <= b_lead_in;
      b_sign_ff    <= b_sign_in;
      b_pfx_ff     <= b_pfx_in;
      b_zf_ff      <= b_zf_in;
      b_pz_ff      <= b_pz_in;
      b_dig_ff     <= b_dig_in;
      pos_ff       <= pos_in;
      ptr_ff       <= ptr_in;
   end

   // digit store: least significant digit at index 0
   always_ff @(posedge clock) begin
      if (cmd.store) begin
         digit_mem[n_ff[5:0]] <= rem_ff;
      end
      rd_ff <= digit_mem[ptr_in];
   end

   always_comb begin
      if (pos8 < b_lead_ff) begin
         char_sel = itaf_pkg::CHAR_SPACE;
      end else if (pos8 < b_sign_ff) begin
         char_sel = sign_char_ff;
      end else if (pos8 < b_pfx_ff) begin
         char_sel = (pos8 == b_sign_ff) ? itaf_pkg::CHAR_ZERO :
                    itaf_pkg::digit_char(itaf_pkg::X_SYMBOL, lower_ff);
      end else if (pos8 < b_pz_ff) begin
         char_sel = itaf_pkg::CHAR_ZERO;
      end else if (pos8 < b_dig_ff) begin
         char_sel = itaf_pkg::digit_char(rd_ff, lower_ff);
      end else begin
         char_sel = itaf_pkg::CHAR_SPACE;
      end
   end

   assign sts.bad_base    = (req_radix < itaf_pkg::RADIX_MIN) || (req_radix > itaf_pkg::RADIX_MAX);
   assign sts.div_done    = (bit_cnt_ff == 6'(itaf_pkg::DIV_STEPS - 1));
   assign sts.more_digits = (quot_ff != 64'd0) && (n_ff < 7'(itaf_pkg::MAX_DIGITS - 1));
   assign sts.emit_last   = (pos_ff == emit_n_ff - 7'd1);

   assign rsp_character = cmd.err ? itaf_pkg::CHAR_NUL : char_sel;
   assign rsp_last      = cmd.err || sts.emit_last;
   assign rsp_status    = cmd.err ? itaf_pkg::STATUS_BAD_BASE :
                          ((sts.emit_last && ovf_ff) ? itaf_pkg::STATUS_TRUNC :
                           itaf_pkg::STATUS_OK);

endmodule

FILE: rtl/integer_to_ascii_formatter.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// printf-style integer conversion, one output character per result.
// ----------------------------------------------------------------------------
//  channel   ports                       handshake
//  request   req_* fields                start high while busy low
//  result    rsp_character/last/status   rsp_valid, one result per cycle
//
// An item occupies the block until its last character is sent: each digit
// takes 64 steps of the bit-serial divider plus a store into the digit memory.
// A bad base returns its error result in the cycle after the request.
// Reset returns the sequencer to idle; no clearing pass is needed.
// Results cannot be stalled; busy stays high until the last one is out.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter #(
   parameter int MAX_CHARS = 64
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [63:0] req_value,
   input  logic [5:0]  req_radix,
   input  logic [5:0]  req_min_width,
   input  logic [5:0]  req_min_digits,
   input  logic        req_left_justify,
   input  logic        req_force_plus,
   input  logic        req_space_sign,
   input  logic        req_alternate_prefix,
   input  logic        req_zero_pad,
   input  logic        req_lower_case,
   input  logic        req_signed_value,
   output logic        rsp_valid,
   output logic [7:0]  rsp_character,
   output logic        rsp_last,
   output logic [1:0]  rsp_status
);

   itaf_pkg::cmd_type cmd;
   itaf_pkg::sts_type sts;

   itaf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .cmd       (cmd),
      .sts       (sts)
   );

   itaf_dpath #(
      .MAX_CHARS (MAX_CHARS)
   ) u_dpath (
      .clock                (clock),
      .cmd                  (cmd),
      .sts                  (sts),
      .req_value            (req_value),
      .req_radix            (req_radix),
      .req_min_width        (req_min_width),
      .req_min_digits       (req_min_digits),
      .req_left_justify     (req_left_justify),
      .req_force_plus       (req_force_plus),
      .req_space_sign       (req_space_sign),
      .req_alternate_prefix (req_alternate_prefix),
      .req_zero_pad         (req_zero_pad),
      .req_lower_case       (req_lower_case),
      .req_signed_value     (req_signed_value),
      .rsp_character        (rsp_character),
      .rsp_last             (rsp_last),
      .rsp_status           (rsp_status)
   );

endmodule

FILE: rtl/itaf_checker.sv
// ----------------------------------------------------------------------------
// itaf_checker
// Port-level checks for the formatter, bound to the top level.
// ----------------------------------------------------------------------------
`include "integer_to_ascii_formatter_assert.svh"

module itaf_checker (
   input logic       clock,
   input logic       reset,
   input logic       start,
   input logic       busy,
   input logic       rsp_valid,
   input logic [7:0] rsp_character,
   input logic       rsp_last,
   input logic [1:0] rsp_status
);

   `ITAF_ASSERT_NOW(a_valid_busy, rsp_valid, busy, "result outside a busy period")
   `ITAF_ASSERT_NOW(a_bad_base, rsp_valid && (rsp_status == itaf_pkg::STATUS_BAD_BASE), rsp_last && (rsp_character == itaf_pkg::CHAR_NUL), "bad base result malformed")
   `ITAF_ASSERT_NOW(a_trunc_last, rsp_valid && (rsp_status == itaf_pkg::STATUS_TRUNC), rsp_last, "truncation flagged before the last result")
   `ITAF_ASSERT_NEXT(a_last_idle, rsp_valid && rsp_last, !busy, "still busy after the last result")
   `ITAF_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "request accepted but not busy")

endmodule

bind integer_to_ascii_formatter itaf_checker u_itaf_checker (
   .clock         (clock),
   .reset         (reset),
   .start         (start),
   .busy          (busy),
   .rsp_valid     (rsp_valid),
   .rsp_character (rsp_character),
   .rsp_last      (rsp_last),
   .rsp_status    (rsp_status)
);

FILE: tb/integer_to_ascii_formatter_tb.sv
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter_tb
// Self-checking bench for the printf-style integer formatter. Directed
// requests cover the corner cases of the layout rules, then random requests
// run under three sender idle mixes. A scoreboard predicts every character
// and checks the strobed results in order.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter_tb;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TEXT_LIMIT     = 64;
   localparam int WATCHDOG_LIMIT = 25000;
   localparam int DRAIN_CYCLES   = 64;
   localparam int RANDOM_ITEMS   = 285;

   localparam string UPPER_GLYPHS = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZ";
   localparam string LOWER_GLYPHS = "0123456789abcdefghijklmnopqrstuvwxyz";

   // flag masks for directed requests
   localparam logic [6:0] FL_NONE   = 7'b0000000;
   localparam logic [6:0] FL_LEFT   = 7'b1000000;
   localparam logic [6:0] FL_PLUS   = 7'b0100000;
   localparam logic [6:0] FL_SPACE  = 7'b0010000;
   localparam logic [6:0] FL_ALT    = 7'b0001000;
   localparam logic [6:0] FL_ZERO   = 7'b0000100;
   localparam logic [6:0] FL_LOWER  = 7'b0000010;
   localparam logic [6:0] FL_SIGNED = 7'b0000001;

   typedef struct {
      logic [63:0] value;
      logic [5:0]  radix;
      logic [5:0]  min_width;
      logic [5:0]  min_digits;
      logic        left_justify;
      logic        force_plus;
      logic        space_sign;
      logic        alternate_prefix;
      logic        zero_pad;
      logic        lower_case;
      logic        signed_value;
   } format_request_type;

   typedef struct {
      logic [7:0]           character;
      logic                 last;
      itaf_pkg::status_type status;
      int                   request_num;
      int                   position;
   } text_char_type;

   class format_scoreboard_type;
      text_char_type expected_text[$];
      int mismatches = 0;
      int requests_noted = 0;

      task report_mismatch(string what);
         mismatches++;
         $display("[%0t] mismatch: %s", $time, what);
      endtask

      function int pending();
         return expected_text.size();
      endfunction

      // predict the full formatted text of one request
      function void note_request(format_request_type r);
         logic [63:0]   magnitude;
         logic [63:0]   rest;
         logic [63:0]   base;
         logic [5:0]    digit_val[itaf_pkg::MAX_DIGITS];
         logic [7:0]    line_text[$];
         logic [7:0]    sign_char;
         string         glyphs;
         int            n;
         int            prec;
         int            pad;
         int            prefix_len;
         int            sent;
         bit            fill_zero;
         text_char_type e;
         requests_noted++;
         e.request_num = requests_noted;
         if (r.radix < itaf_pkg::RADIX_MIN || r.radix > itaf_pkg::RADIX_MAX) begin
            e.character = itaf_pkg::CHAR_NUL;
            e.last = 1'b1;
            e.status = itaf_pkg::STATUS_BAD_BASE;
            e.position = 0;
            expected_text.push_back(e);
            return;
         end
         glyphs = r.lower_case ? LOWER_GLYPHS : UPPER_GLYPHS;
         sign_char = itaf_pkg::CHAR_NUL;
         if (r.signed_value && r.value[63]) begin
            sign_char = itaf_pkg::CHAR_MINUS;
            magnitude = 64'd0 - r.value;
         end else begin
            magnitude = r.value;
            if (r.force_plus) sign_char = itaf_pkg::CHAR_PLUS;
            else if (r.space_sign) sign_char = itaf_pkg::CHAR_SPACE;
         end
         base = 64'(r.radix);
         n = 0;
         rest = magnitude;
         if (magnitude == 64'd0) begin
            digit_val[0] = 6'd0;
            n = 1;
         end else begin
            while (rest != 64'd0 && n < itaf_pkg::MAX_DIGITS) begin
               digit_val[n] = 6'(rest % base);
               rest = rest / base;
               n++;
            end
         end
         prec = (int'(r.min_digits) > n) ? int'(r.min_digits) : n;
         // octal alternate form needs a leading zero digit
         if (r.alternate_prefix && r.radix == itaf_pkg::RADIX_OCT && prec == n &&
             digit_val[n-1] != 6'd0)
            prec = n + 1;
         prefix_len = (r.alternate_prefix && r.radix == itaf_pkg::RADIX_HEX &&
                       magnitude != 64'd0) ? 2 : 0;
         fill_zero = r.zero_pad && !r.left_justify && r.min_digits == 6'd0;
         pad = int'(r.min_width) - ((sign_char != itaf_pkg::CHAR_NUL) ? 1 : 0)
               - prefix_len - prec;
         if (pad < 0) pad = 0;

         if (!fill_zero && !r.left_justify)
            repeat (pad) line_text.push_back(itaf_pkg::CHAR_SPACE);
         if (sign_char != itaf_pkg::CHAR_NUL) line_text.push_back(sign_char);
         if (prefix_len != 0) begin
            line_text.push_back(itaf_pkg::CHAR_ZERO);
            line_text.push_back(glyphs[itaf_pkg::X_SYMBOL]);
         end
         if (fill_zero) repeat (pad) line_text.push_back(itaf_pkg::CHAR_ZERO);
         repeat (prec - n) line_text.push_back(itaf_pkg::CHAR_ZERO);
         for (int k = n - 1; k >= 0; k--) line_text.push_back(glyphs[digit_val[k]]);
         if (r.left_justify) repeat (pad) line_text.push_back(itaf_pkg::CHAR_SPACE);

         sent = (line_text.size() > TEXT_LIMIT) ? TEXT_LIMIT : line_text.size();
         for (int k = 0; k < sent; k++) begin
            e.character = line_text[k];
            e.position = k;
            e.last = (k == sent - 1);
            e.status = itaf_pkg::STATUS_OK;
            if (e.last && line_text.size() > TEXT_LIMIT) e.status = itaf_pkg::STATUS_TRUNC;
            expected_text.push_back(e);
         end
      endfunction

      task check_result(logic [7:0] character, logic last, logic [1:0] status);
         text_char_type e;
         if (expected_text.size() == 0) begin
            report_mismatch($sformatf("unexpected result, character %h", character));
            return;
         end
         e = expected_text.pop_front();
         if (character !== e.character)
            report_mismatch($sformatf("request %0d char %0d: character %h, wanted %h",
               e.request_num, e.position, character, e.character));
         if (last !== e.last)
            report_mismatch($sformatf("request %0d char %0d: last %b, wanted %b",
               e.request_num, e.position, last, e.last));
         if (status !== e.status)
            report_mismatch($sformatf("request %0d char %0d: status %0d, wanted %s",
               e.request_num, e.position, status, e.status.name()));
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset;
   logic        start;
   logic        busy;
   logic [63:0] req_value;
   logic [5:0]  req_radix;
   logic [5:0]  req_min_width;
   logic [5:0]  req_min_digits;
   logic        req_left_justify;
   logic        req_force_plus;
   logic        req_space_sign;
   logic        req_alternate_prefix;
   logic        req_zero_pad;
   logic        req_lower_case;
   logic        req_signed_value;
   logic        rsp_valid;
   logic [7:0]  rsp_character;
   logic        rsp_last;
   logic [1:0]  rsp_status;

   format_scoreboard_type board = new;
   int sender_idle_pct;
   int quiet_cycles = 0;

   integer_to_ascii_formatter #(
      .MAX_CHARS(TEXT_LIMIT)
   ) i_dut (
      .clock                (clock),
      .reset                (reset),
      .start                (start),
      .busy                 (busy),
      .req_value            (req_value),
      .req_radix            (req_radix),
      .req_min_width        (req_min_width),
      .req_min_digits       (req_min_digits),
      .req_left_justify     (req_left_justify),
      .req_force_plus       (req_force_plus),
      .req_space_sign       (req_space_sign),
      .req_alternate_prefix (req_alternate_prefix),
      .req_zero_pad         (req_zero_pad),
      .req_lower_case       (req_lower_case),
      .req_signed_value     (req_signed_value),
      .rsp_valid            (rsp_valid),
      .rsp_character        (rsp_character),
      .rsp_last             (rsp_last),
      .rsp_status           (rsp_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1)
         board.check_result(rsp_character, rsp_last, rsp_status);
   end

   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   function automatic format_request_type make_request(logic [63:0] value, logic [5:0] radix,
                                                       logic [5:0] min_width,
                                                       logic [5:0] min_digits,
                                                       logic [6:0] flags);
      format_request_type r;
      r.value = value;
      r.radix = radix;
      r.min_width = min_width;
      r.min_digits = min_digits;
      {r.left_justify, r.force_plus, r.space_sign, r.alternate_prefix,
       r.zero_pad, r.lower_case, r.signed_value} = flags;
      return r;
   endfunction

   function automatic format_request_type random_request();
      logic [63:0] value;
      logic [5:0]  radix;
      logic [5:0]  min_width;
      logic [5:0]  min_digits;
      int          pick;
      pick = $urandom_range(99);
      if (pick < 20) value = 64'($urandom_range(1000));
      else if (pick < 35) begin
         case ($urandom_range(5))
            0: value = 64'd0;
            1: value = 64'd1;
            2: value = '1;
            3: value = 64'h8000_0000_0000_0000;
            4: value = 64'h7FFF_FFFF_FFFF_FFFF;
            default: value = 64'h8000_0000_0000_0001;
         endcase
      end else if (pick < 70) value = {$urandom, $urandom};
      else value = {$urandom, $urandom} >> $urandom_range(63);

      pick = $urandom_range(99);
      if (pick < 8) begin
         if ($urandom_range(1)) radix = 6'($urandom_range(1));
         else radix = 6'($urandom_range(37, 63));
      end else if (pick < 54) begin
         case ($urandom_range(3))
            0: radix = itaf_pkg::RADIX_MIN;
            1: radix = itaf_pkg::RADIX_OCT;
            2: radix = 6'd10;
            default: radix = itaf_pkg::RADIX_HEX;
         endcase
      end else radix = 6'($urandom_range(2, 36));

      min_width = ($urandom_range(99) < 70) ? 6'($urandom_range(24)) : 6'($urandom_range(63));
      pick = $urandom_range(99);
      if (pick < 50) min_digits = 6'd0;
      else if (pick < 80) min_digits = 6'($urandom_range(1, 24));
      else min_digits = 6'($urandom_range(63));
      return make_request(value, radix, min_width, min_digits, 7'($urandom));
   endfunction

   // present one request and hold it until the block takes it
   task automatic send_request(format_request_type r);
      req_value            <= r.value;
      req_radix            <= r.radix;
      req_min_width        <= r.min_width;
      req_min_digits       <= r.min_digits;
      req_left_justify     <= r.left_justify;
      req_force_plus       <= r.force_plus;
      req_space_sign       <= r.space_sign;
      req_alternate_prefix <= r.alternate_prefix;
      req_zero_pad         <= r.zero_pad;
      req_lower_case       <= r.lower_case;
      req_signed_value     <= r.signed_value;
      forever begin
         start <= ($urandom_range(99) >= sender_idle_pct);
         @(posedge clock);
         if (start && !busy) break;
      end
      board.note_request(r);
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req_value = '0;
      req_radix = '0;
      req_min_width = '0;
      req_min_digits = '0;
      req_left_justify = 1'b0;
      req_force_plus = 1'b0;
      req_space_sign = 1'b0;
      req_alternate_prefix = 1'b0;
      req_zero_pad = 1'b0;
      req_lower_case = 1'b0;
      req_signed_value = 1'b0;
      sender_idle_pct = 12;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      send_request(make_request(64'd0, 6'd10, 6'd0, 6'd0, FL_NONE));
      send_request(make_request('1, itaf_pkg::RADIX_MIN, 6'd0, 6'd0, FL_NONE));
      send_request(make_request('1, itaf_pkg::RADIX_MIN, 6'd0, 6'd0, FL_PLUS));
      send_request(make_request(64'h8000_0000_0000_0000, 6'd10, 6'd0, 6'd0, FL_SIGNED));
      send_request(make_request('1, itaf_pkg::RADIX_HEX, 6'd63, 6'd0,
                                FL_SIGNED | FL_ZERO | FL_ALT));
      send_request(make_request(64'd77, 6'd0, 6'd5, 6'd0, FL_NONE));
      send_request(make_request(64'd77, 6'd1, 6'd0, 6'd0, FL_PLUS));
      send_request(make_request(64'd77, 6'd37, 6'd0, 6'd0, FL_NONE));
      send_request(make_request('1, 6'd63, 6'd63, 6'd63, 7'b1111111));
      send_request(make_request('1, itaf_pkg::RADIX_MAX, 6'd0, 6'd0, FL_LOWER));
      send_request(make_request('1, itaf_pkg::RADIX_MAX, 6'd0, 6'd0, FL_ALT));
      send_request(make_request(64'd8, itaf_pkg::RADIX_OCT, 6'd0, 6'd0, FL_ALT));
      send_request(make_request(64'd0, itaf_pkg::RADIX_OCT, 6'd0, 6'd0, FL_ALT));
      send_request(make_request(64'd8, itaf_pkg::RADIX_OCT, 6'd0, 6'd5, FL_ALT));
      send_request(make_request(64'd0, itaf_pkg::RADIX_HEX, 6'd0, 6'd0, FL_ALT));
      send_request(make_request(64'd255, itaf_pkg::RADIX_HEX, 6'd10, 6'd0,
                                FL_ALT | FL_LOWER | FL_ZERO));
      send_request(make_request(64'd42, 6'd10, 6'd6, 6'd0, FL_SPACE));
      send_request(make_request(64'd42, 6'd10, 6'd0, 6'd0, FL_PLUS | FL_SPACE));
      send_request(make_request(64'd42, 6'd10, 6'd20, 6'd0, FL_LEFT | FL_ZERO | FL_PLUS));
      send_request(make_request(64'd1, itaf_pkg::RADIX_HEX, 6'd63, 6'd63,
                                FL_ZERO | FL_PLUS | FL_ALT));
      send_request(make_request(64'd12345, 6'd10, 6'd63, 6'd0, FL_NONE));
      send_request(make_request(64'h8000_0000_0000_0000, 6'd3, 6'd0, 6'd0, FL_PLUS));
      send_request(make_request(-64'sd5, 6'd7, 6'd8, 6'd3, FL_LEFT | FL_SIGNED));
      send_request(make_request(64'h7FFF_FFFF_FFFF_FFFF, 6'd10, 6'd0, 6'd0,
                                FL_SPACE | FL_SIGNED));
      send_request(make_request(64'd0, 6'd10, 6'd63, 6'd0, FL_ZERO | FL_SIGNED));

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: sender_idle_pct = 12;
            1: sender_idle_pct = 49;
            default: sender_idle_pct = 0;
         endcase
         for (int i = 0; i < RANDOM_ITEMS / 3; i++) send_request(random_request());
      end
      start <= 1'b0;

      while (board.pending() > 0) @(posedge clock);
      // catch any stray characters after the last expected one
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.mismatches == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
